### src/ocean_irrigation_kernel_sum_core_defines.svh
// ----------------------------------------------------------------------------
// Ocean irrigation kernel sum - assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef OCEAN_IRRIGATION_KERNEL_SUM_CORE_DEFINES_SVH
`define OCEAN_IRRIGATION_KERNEL_SUM_CORE_DEFINES_SVH

// same-cycle implication
`define OIKS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OIKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/oiks_pkg.sv
// ----------------------------------------------------------------------------
// oiks_pkg
// Types and constants shared by the ocean irrigation kernel sum core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package oiks_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_RADIUS     = 10;

  localparam int GRID_W      = 9;
  localparam int CELL_W      = 8;
  localparam int WATER_W     = 32;
  localparam int IRR_W       = 48;
  localparam int WEIGHT_W    = 16;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic               ocean;
    logic [WATER_W-1:0] water;
  } cell_t;

  typedef struct packed {
    logic issue;
    logic acc_clr;
  } mac_ctl_t;

endpackage

`default_nettype wire

### src/oiks_store.sv
// ----------------------------------------------------------------------------
// oiks_store
// Cell store: water and ocean flag per cell, one write and one read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oiks_store import oiks_pkg::*; #(
  parameter int AW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire cell_t         wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output cell_t              rdata
);

  cell_t mem [2**AW];
  cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/oiks_mac.sv
// ----------------------------------------------------------------------------
// oiks_mac
// Weight ROM lookup, water x weight multiply and 48-bit accumulate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oiks_mac import oiks_pkg::*; #(
  parameter int RADIUS = DEF_RADIUS,
  parameter int SW     = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mac_ctl_t         ctl,
  input  wire logic [SW-1:0]    wt_idx,
  input  wire cell_t            rdata,
  output logic      [IRR_W-1:0] sum_nxt
);

  localparam int ROM_SIZE = 2 * RADIUS * RADIUS + 1;
  localparam logic [63:0] LN2_Q32 = 64'd2977044472;
  localparam logic [63:0] ONE_Q32 = 64'd1 << 32;

  // shift-subtract divide, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 1/(ln(1+sqrt(s))+1) in Q0.16, saturated
  function automatic logic [WEIGHT_W-1:0] weight_of(input logic [31:0] s);
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] k;
    logic        done;
    logic [63:0] m;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] ln;
    logic [63:0] den;
    logic [63:0] q;
    t    = isqrt64({s, 32'd0});
    x    = 64'd65536 + t;
    k    = '0;
    done = 1'b0;
    for (int j = 0; j < 64; j++) begin
      if (!done) begin
        if ((x >> k) >= 64'd131072) begin
          k = k + 64'd1;
        end else begin
          done = 1'b1;
        end
      end
    end
    m    = (x << 16) >> k;
    u    = udiv64((m - ONE_Q32) << 32, m + ONE_Q32);
    u2   = (u * u) >> 32;
    term = u;
    sum  = '0;
    for (int n = 1; n < 40; n += 2) begin
      sum  = sum + udiv64(term, 64'(n));
      term = (term * u2) >> 32;
    end
    ln  = k * LN2_Q32 + 2 * sum;
    den = ln + ONE_Q32;
    q   = udiv64((64'd1 << 48) + (den >> 1), den);
    if (q > 64'hFFFF) begin
      q = 64'hFFFF;
    end
    return q[WEIGHT_W-1:0];
  endfunction

  logic [WEIGHT_W-1:0] rom [ROM_SIZE];

  for (genvar g = 0; g < ROM_SIZE; g++) begin : g_rom
    localparam logic [WEIGHT_W-1:0] W = weight_of(32'(g));
    assign rom[g] = W;
  end

  logic                    v_b_r;
  logic [SW-1:0]           s_b_r;
  logic                    v_c_r;
  logic [WEIGHT_W-1:0]     w_c_r;
  logic [WATER_W-1:0]      water_c_r;
  logic                    v_d_r;
  logic [WATER_W+WEIGHT_W-1:0] prod_d_r;
  logic [IRR_W-1:0]        acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
    end else begin
      v_b_r <= ctl.issue;
      v_c_r <= v_b_r && rdata.ocean;
      v_d_r <= v_c_r;
    end
  end

  always_ff @(posedge clk) begin
    s_b_r     <= wt_idx;
    w_c_r     <= rom[s_b_r];
    water_c_r <= rdata.water;
    prod_d_r  <= water_c_r * w_c_r;
    acc_r     <= sum_nxt;
  end

  always_comb begin
    if (ctl.acc_clr) begin
      sum_nxt = '0;
    end else if (v_d_r) begin
      sum_nxt = acc_r + IRR_W'(prod_d_r[WATER_W+WEIGHT_W-1:WEIGHT_W]);
    end else begin
      sum_nxt = acc_r;
    end
  end

endmodule

`default_nettype wire

### src/oiks_seq.sv
// ----------------------------------------------------------------------------
// oiks_seq
// Sequencer: store clearing, loads, window sweep, drain and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oiks_seq import oiks_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int RADIUS     = DEF_RADIUS,
  parameter int XW         = 8,
  parameter int YW         = 8,
  parameter int SW         = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire logic                req_kind,
  input  wire logic [CELL_W-1:0]   req_x,
  input  wire logic [CELL_W-1:0]   req_y,
  input  wire logic [WATER_W-1:0]  req_water,
  input  wire logic                req_ocean,
  input  wire logic [GRID_W-1:0]   grid_w,
  input  wire logic [GRID_W-1:0]   grid_h,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output logic      [IRR_W-1:0]    res_data,
  output logic                     mem_we,
  output logic      [XW+YW-1:0]    mem_waddr,
  output cell_t                    mem_wdata,
  output logic                     mem_re,
  output logic      [XW+YW-1:0]    mem_raddr,
  output mac_ctl_t                 mac_ctl,
  output logic      [SW-1:0]       wt_idx,
  input  wire logic [IRR_W-1:0]    sum_nxt
);

  localparam int AW = XW + YW;
  localparam int OW = $clog2(2 * RADIUS + 1);
  localparam logic [OW-1:0] OFF_LAST = OW'(2 * RADIUS);
  localparam logic [OW-1:0] OFF_MID  = OW'(RADIUS);
  localparam logic [1:0]    DRAIN_LAST = 2'd2;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [CELL_W-1:0] cx_r, cx_nxt;
  logic [CELL_W-1:0] cy_r, cy_nxt;
  logic              ok_r, ok_nxt;
  logic [OW-1:0]     ix_r, ix_nxt;
  logic [OW-1:0]     iy_r, iy_nxt;
  logic [1:0]        drain_r, drain_nxt;
  logic              res_valid_r, res_valid_nxt;
  logic [IRR_W-1:0]  res_data_r;
  logic              res_load;

  logic [OW-1:0]     ad_x, ad_y;
  logic [2*OW-1:0]   sq_x, sq_y;
  logic [2*OW:0]     s_sum;
  logic [9:0]        sx, sy;
  logic              in_x, in_y;
  logic              load_in_store;

  // window offsets and distance index
  always_comb begin
    ad_x   = (ix_r >= OFF_MID) ? ix_r - OFF_MID : OFF_MID - ix_r;
    ad_y   = (iy_r >= OFF_MID) ? iy_r - OFF_MID : OFF_MID - iy_r;
    sq_x   = ad_x * ad_x;
    sq_y   = ad_y * ad_y;
    s_sum  = {1'b0, sq_x} + {1'b0, sq_y};
    wt_idx = SW'(s_sum);
    sx     = {2'b00, cx_r} + 10'(ix_r) - 10'(RADIUS);
    sy     = {2'b00, cy_r} + 10'(iy_r) - 10'(RADIUS);
    in_x   = !sx[9] && (sx[8:0] < grid_w);
    in_y   = !sy[9] && (sy[8:0] < grid_h);
    mem_raddr = {YW'(sy[8:0]), XW'(sx[8:0])};
    load_in_store = (32'(req_x) < MAX_WIDTH) && (32'(req_y) < MAX_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    ok_r    <= ok_nxt;
    ix_r    <= ix_nxt;
    iy_r    <= iy_nxt;
    drain_r <= drain_nxt;
    if (res_load) begin
      res_data_r <= sum_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    ok_nxt      = ok_r;
    ix_nxt      = ix_r;
    iy_nxt      = iy_r;
    drain_nxt   = drain_r;
    req_ready   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = clr_cnt_r;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mac_ctl     = '0;
    res_load    = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_kind == KIND_QUERY) begin
            cx_nxt          = req_x;
            cy_nxt          = req_y;
            ok_nxt          = ({1'b0, req_x} < grid_w) && ({1'b0, req_y} < grid_h);
            ix_nxt          = '0;
            iy_nxt          = '0;
            mac_ctl.acc_clr = 1'b1;
            state_nxt       = ST_RUN;
          end else if (load_in_store) begin
            mem_we    = 1'b1;
            mem_waddr = {YW'(req_y), XW'(req_x)};
            mem_wdata = '{ocean: req_ocean, water: req_water};
          end
        end
      end
      ST_RUN: begin
        mem_re        = 1'b1;
        mac_ctl.issue = ok_r && in_x && in_y;
        if (ix_r == OFF_LAST) begin
          ix_nxt = '0;
          if (iy_r == OFF_LAST) begin
            drain_nxt = '0;
            state_nxt = ST_DRAIN;
          end else begin
            iy_nxt = iy_r + 1'b1;
          end
        end else begin
          ix_nxt = ix_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (drain_r != DRAIN_LAST) begin
          drain_nxt = drain_r + 1'b1;
        end else if (!res_valid_r || res_ready) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (res_load) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end else begin
      res_valid_nxt = res_valid_r;
    end
  end

  assign res_valid = res_valid_r;
  assign res_data  = res_data_r;

endmodule

`default_nettype wire

### src/ocean_irrigation_kernel_sum_core.sv
// ----------------------------------------------------------------------------
// ocean_irrigation_kernel_sum_core
// Per-cell water store with a windowed, distance-weighted ocean irrigation sum.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready  tuser kind, tdata cell_x/cell_y/water/is_ocean
// out_     out  out_tvalid/out_tready tdata irrigation
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (grid_width, grid_height)
//
// Load request: written to the store in the cycle it is taken. Query request: sweeps
// the (2*RADIUS+1)^2 window, 441 cells at RADIUS 10, one window cell per cycle through
// the single store read port. After reset all 2^(XW+YW) store entries (65536 at defaults)
// are cleared with in_tready low; cfg writes are taken throughout.
// A query result waiting on out_tready holds off the next query's hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ocean_irrigation_kernel_sum_core import oiks_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int RADIUS     = DEF_RADIUS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // cell_x, cell_y, water, is_ocean, pad
  input  wire logic                   in_tuser,   // kind
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // irrigation
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_index,
  input  wire logic [GRID_W-1:0]      cfg_data
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = XW + YW;
  localparam int SW = $clog2(2 * RADIUS * RADIUS + 1);

  logic [GRID_W-1:0] grid_width_r;
  logic [GRID_W-1:0] grid_height_r;
  logic [GRID_W-1:0] grid_w_eff;
  logic [GRID_W-1:0] grid_h_eff;

  logic [CELL_W-1:0]  req_x;
  logic [CELL_W-1:0]  req_y;
  logic [WATER_W-1:0] req_water;
  logic               req_ocean;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  cell_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  cell_t         mem_rdata;
  mac_ctl_t      mac_ctl;
  logic [SW-1:0] wt_idx;
  logic [IRR_W-1:0] sum_nxt;
  logic [IRR_W-1:0] res_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_W'(256);
      grid_height_r <= GRID_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  grid_width_r  <= cfg_data;
        CFG_IDX_HEIGHT: grid_height_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    grid_w_eff = (32'(grid_width_r) > MAX_WIDTH) ? GRID_W'(MAX_WIDTH) : grid_width_r;
    grid_h_eff = (32'(grid_height_r) > MAX_HEIGHT) ? GRID_W'(MAX_HEIGHT) : grid_height_r;
  end

  assign req_x     = in_tdata[7:0];
  assign req_y     = in_tdata[15:8];
  assign req_water = in_tdata[47:16];
  assign req_ocean = in_tdata[48];

  oiks_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .RADIUS     (RADIUS),
    .XW         (XW),
    .YW         (YW),
    .SW         (SW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_kind  (in_tuser),
    .req_x     (req_x),
    .req_y     (req_y),
    .req_water (req_water),
    .req_ocean (req_ocean),
    .grid_w    (grid_w_eff),
    .grid_h    (grid_h_eff),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_data  (res_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mac_ctl   (mac_ctl),
    .wt_idx    (wt_idx),
    .sum_nxt   (sum_nxt)
  );

  oiks_store #(
    .AW (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  oiks_mac #(
    .RADIUS (RADIUS),
    .SW     (SW)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .wt_idx  (wt_idx),
    .rdata   (mem_rdata),
    .sum_nxt (sum_nxt)
  );

  assign out_tdata = OUT_TDATA_W'(res_data);

endmodule

`default_nettype wire

### src/oiks_checker.sv
// ----------------------------------------------------------------------------
// oiks_checker
// Port-level timing checks for the ocean irrigation kernel sum core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ocean_irrigation_kernel_sum_core_defines.svh"

module oiks_checker import oiks_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  logic load_req;
  logic query_req;
  logic out_stall;

  assign load_req  = in_tvalid && in_tready && (in_tuser == KIND_LOAD);
  assign query_req = in_tvalid && in_tready && (in_tuser == KIND_QUERY);
  assign out_stall = out_tvalid && !out_tready;

  `OIKS_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata), "result not held")
  `OIKS_ASSERT_NEXT(a_load_single, load_req, in_tready, "load not done in one cycle")
  `OIKS_ASSERT_NEXT(a_query_busy, query_req, !in_tready && !$rose(out_tvalid), "query not busy")
  `OIKS_ASSERT_SAME(a_result_from_sweep, $rose(out_tvalid), $past(!in_tready), "stray result")

endmodule

bind ocean_irrigation_kernel_sum_core oiks_checker u_oiks_checker (.*);

`default_nettype wire
